// ===== rtl/core/bed_pkg.sv =====
// Shared types, character codes and helper functions for the escaped binary string decoder.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package bed_pkg;

	localparam logic [7:0] BSLASH = 8'h5C;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;

	localparam int MAX_OUT     = 4;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_LEAD  = 2'd1,
		MODE_ESC   = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		HELD_NONE   = 2'd0,
		HELD_BSLASH = 2'd1,
		HELD_ONE    = 2'd2,
		HELD_TWO    = 2'd3
	} held_t;

	// one decoded input: up to four bytes, replayed by the back end
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [1:0]              cnt_m1;
		logic                    has_bytes;
		logic                    str_end;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_7);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			v = c[3:0] + 4'd9;
		return v;
	endfunction

	function automatic logic [7:0] oct_char(input logic [2:0] d);
		return {CH_0[7:3], d};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bed_front.sv =====
// Front end: accepts input beats, runs the escape/hex decode state and builds jobs,
// one per beat that yields bytes or has in_last. Depends on bed_pkg; feeds bed_queue.
`default_nettype none

module bed_front
	import bed_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire q_status_t  q_stat,
	output logic            push,
	output job_t            push_job
);

	mode_t      mode_q, mode_d;
	held_t      held_q, held_d;
	logic [5:0] dig_q, dig_d;
	logic [3:0] nib_q, nib_d;
	logic       half_q, half_d;

	logic                    accept;
	logic [MAX_OUT-1:0][7:0] b;
	logic [2:0]              n;
	logic                    esc;
	logic                    do_fresh;
	logic [2:0]              d;
	logic                    oct;
	logic [3:0]              hv;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign d        = in_byte[2:0];
	assign oct      = is_oct(in_byte);
	assign hv       = hex_val(in_byte);

	always_comb begin
		mode_d   = mode_q;
		held_d   = held_q;
		dig_d    = dig_q;
		nib_d    = nib_q;
		half_d   = half_q;
		b        = '0;
		n        = 3'd0;
		esc      = 1'b0;
		do_fresh = 1'b0;

		case (mode_q)
			MODE_START: begin
				if (in_byte == BSLASH && !in_last) begin
					mode_d = MODE_LEAD;
					held_d = HELD_BSLASH;
				end else begin
					mode_d = MODE_ESC;
					held_d = HELD_NONE;
					esc    = 1'b1;
				end
			end
			MODE_LEAD: begin
				if (in_byte == CH_X) begin
					mode_d = MODE_HEX;
					held_d = HELD_NONE;
					half_d = 1'b0;
				end else begin
					mode_d = MODE_ESC;
					esc    = 1'b1;
				end
			end
			MODE_ESC: esc = 1'b1;
			default: begin
				if (!half_q) begin
					nib_d  = hv;
					half_d = 1'b1;
				end else begin
					b[n[1:0]] = {nib_q, hv};
					n         = n + 3'd1;
					half_d    = 1'b0;
				end
			end
		endcase

		if (esc) begin
			case (held_d)
				HELD_NONE: do_fresh = 1'b1;
				HELD_BSLASH: begin
					if (oct && !in_last) begin
						held_d = HELD_ONE;
						dig_d  = {3'd0, d};
					end else if (in_byte == BSLASH) begin
						b[n[1:0]] = BSLASH;
						n         = n + 3'd1;
						held_d    = HELD_NONE;
					end else begin
						b[n[1:0]] = BSLASH;
						n         = n + 3'd1;
						do_fresh  = 1'b1;
					end
				end
				HELD_ONE: begin
					if (oct && !in_last) begin
						held_d = HELD_TWO;
						dig_d  = {dig_d[2:0], d};
					end else begin
						b[n[1:0]] = BSLASH;
						n         = n + 3'd1;
						b[n[1:0]] = oct_char(dig_d[2:0]);
						n         = n + 3'd1;
						do_fresh  = 1'b1;
					end
				end
				default: begin
					if (oct) begin
						// d1*64 + d2*8 + d3, wrapped to a byte
						b[n[1:0]] = {dig_d[4:0], d};
						n         = n + 3'd1;
						held_d    = HELD_NONE;
					end else begin
						b[n[1:0]] = BSLASH;
						n         = n + 3'd1;
						b[n[1:0]] = oct_char(dig_d[5:3]);
						n         = n + 3'd1;
						b[n[1:0]] = oct_char(dig_d[2:0]);
						n         = n + 3'd1;
						do_fresh  = 1'b1;
					end
				end
			endcase
			if (do_fresh) begin
				if (in_byte == BSLASH && !in_last) begin
					held_d = HELD_BSLASH;
				end else begin
					held_d    = HELD_NONE;
					b[n[1:0]] = in_byte;
					n         = n + 3'd1;
				end
			end
		end

		if (in_last) begin
			mode_d = MODE_START;
			held_d = HELD_NONE;
			dig_d  = 6'd0;
			nib_d  = 4'd0;
			half_d = 1'b0;
		end
	end

	assign push               = accept && ((n != 3'd0) || in_last);
	assign push_job.bytes     = b;
	assign push_job.cnt_m1    = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
	assign push_job.has_bytes = (n != 3'd0);
	assign push_job.str_end   = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			held_q <= HELD_NONE;
			dig_q  <= 6'd0;
			nib_q  <= 4'd0;
			half_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			dig_q  <= dig_d;
			nib_q  <= nib_d;
			half_q <= half_d;
		end
	end

`ifndef SYNTH
	a_lead_holds_bslash: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_LEAD |-> held_q == HELD_BSLASH)
		else $error("leading backslash state without held backslash");
	a_hex_holds_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HEX |-> held_q == HELD_NONE)
		else $error("hex form with escape digits held");
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> mode_q == MODE_START && !half_q && held_q == HELD_NONE)
		else $error("state not cleared after end of string");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bed_queue.sv =====
// Short job queue between the decode front end and the output back end.
// Depends on bed_pkg; written by bed_front, read by bed_back.
`default_nettype none

module bed_queue
	import bed_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_status_t stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CntW'(Depth));
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bed_back.sv =====
// Back end: walks the bytes of the head job and presents one result per beat in an output register.
// Depends on bed_pkg; reads bed_queue.
`default_nettype none

module bed_back
	import bed_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire job_t       head,
	input  wire q_status_t  q_stat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            string_end
);

	logic [1:0] idx_q;
	logic       ovalid_q;
	logic [7:0] byte_q;
	logic       bval_q;
	logic       rlast_q;
	logic       send_q;
	logic       load;
	logic       job_done;

	// the register refills from the head job when it is empty or when its beat is taken
	assign load     = !q_stat.empty && (!ovalid_q || !out_stall);
	assign job_done = (idx_q == head.cnt_m1);
	assign pop      = load && job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q    <= job_done ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= head.has_bytes ? head.bytes[idx_q] : 8'd0;
			bval_q  <= head.has_bytes;
			rlast_q <= job_done;
			send_q  <= job_done && head.str_end;
		end
	end

	assign out_valid  = ovalid_q;
	assign out_byte   = byte_q;
	assign byte_valid = bval_q;
	assign run_last   = rlast_q;
	assign string_end = send_q;

`ifndef SYNTH
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string end on a result that is not the last of its beat");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'd0 && string_end)
		else $error("empty result outside end of string");
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> idx_q <= head.cnt_m1)
		else $error("byte index past end of job");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bytea_escape_decoder.sv =====
// Escaped binary string decoder, top level: one character in, zero to four bytes out.
// Depends on bed_pkg, bed_front, bed_queue, bed_back.
//
// Input channel in_valid/in_stall carries one character (in_byte) and in_last,
// which marks the final character of a string. Output channel out_valid/out_stall
// carries one result beat: out_byte, byte_valid, run_last (last result of its input
// beat) and string_end (final result of the string). A string whose final character
// yields no byte ends with one beat that has byte_valid low.
// Results of an accepted input beat pass through the job queue and then the output register.
// Throughput: one input beat per cycle while out_stall is low and each beat yields at
// most one byte; a beat that yields several bytes holds the single output register until
// all its bytes are out. QueueDepth job entries sit between decode and output, so input
// is taken while results wait; in_stall rises only when the job queue is full.
// While out_stall is high the output beat holds; decoding continues until the queue fills.
// Reset (arst_n low) clears decode state, the queue and the output register; the block
// then expects the start of a new string. After in_last the state also returns to start.
`default_nettype none

module bytea_escape_decoder
	import bed_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            string_end
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head;

	bed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	bed_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	bed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

`default_nettype wire

// ===== sim/bytea_escape_decoder_test.sv =====
// Self-checking bench for bytea_escape_decoder: directed and random escaped strings in,
// decoded beats out, compared against an in-bench decoder model held in a scoreboard class.
// Depends on bed_pkg (character codes, mode and held-state enums) and the decoder RTL.

class bytea_scoreboard;
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_end;
		logic       str_end;
	} beat_t;

	beat_t          decoded_due[$];
	logic [7:0]     run_out[$];
	bed_pkg::mode_t mode;
	bed_pkg::held_t held;
	logic [5:0]     digits;
	logic [3:0]     hi_nib;
	logic           half;
	int             errors;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		mode   = bed_pkg::MODE_START;
		held   = bed_pkg::HELD_NONE;
		digits = '0;
		hi_nib = '0;
		half   = 1'b0;
	endfunction

	function int pending();
		return decoded_due.size();
	endfunction

	function void put(logic [7:0] b);
		run_out.push_back(b);
	endfunction

	function logic octal(logic [7:0] c);
		return c >= bed_pkg::CH_0 && c <= bed_pkg::CH_7;
	endfunction

	// anything outside 0-9, a-f, A-F decodes as zero
	function logic [3:0] nibble_of(logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "0" && c <= "9")
			v = c - "0";
		else if (c >= "a" && c <= "f")
			v = c - "a" + 8'd10;
		else if (c >= "A" && c <= "F")
			v = c - "A" + 8'd10;
		return v[3:0];
	endfunction

	function void take_plain(logic [7:0] c, logic last);
		if (c == bed_pkg::BSLASH && !last) begin
			held = bed_pkg::HELD_BSLASH;
		end else begin
			held = bed_pkg::HELD_NONE;
			put(c);
		end
	endfunction

	function void escape_step(logic [7:0] c, logic last);
		case (held)
			bed_pkg::HELD_NONE: begin
				take_plain(c, last);
			end
			bed_pkg::HELD_BSLASH: begin
				if (octal(c) && !last) begin
					held   = bed_pkg::HELD_ONE;
					digits = {3'b000, c[2:0]};
				end else if (c == bed_pkg::BSLASH) begin
					put(bed_pkg::BSLASH);
					held = bed_pkg::HELD_NONE;
				end else begin
					put(bed_pkg::BSLASH);
					take_plain(c, last);
				end
			end
			bed_pkg::HELD_ONE: begin
				if (octal(c) && !last) begin
					held   = bed_pkg::HELD_TWO;
					digits = {digits[2:0], c[2:0]};
				end else begin
					put(bed_pkg::BSLASH);
					put(bed_pkg::CH_0 | {5'd0, digits[2:0]});
					take_plain(c, last);
				end
			end
			default: begin
				// third digit completes even on the final char; top bit of d1 wraps away
				if (octal(c)) begin
					put({digits[4:0], c[2:0]});
					held = bed_pkg::HELD_NONE;
				end else begin
					put(bed_pkg::BSLASH);
					put(bed_pkg::CH_0 | {5'd0, digits[5:3]});
					put(bed_pkg::CH_0 | {5'd0, digits[2:0]});
					take_plain(c, last);
				end
			end
		endcase
	endfunction

	function void unescape_char(logic [7:0] c, logic last);
		int n;
		run_out.delete();
		case (mode)
			bed_pkg::MODE_START: begin
				if (c == bed_pkg::BSLASH && !last) begin
					mode = bed_pkg::MODE_LEAD;
					held = bed_pkg::HELD_BSLASH;
				end else begin
					mode = bed_pkg::MODE_ESC;
					held = bed_pkg::HELD_NONE;
					escape_step(c, last);
				end
			end
			bed_pkg::MODE_LEAD: begin
				if (c == bed_pkg::CH_X) begin
					mode = bed_pkg::MODE_HEX;
					held = bed_pkg::HELD_NONE;
					half = 1'b0;
				end else begin
					mode = bed_pkg::MODE_ESC;
					escape_step(c, last);
				end
			end
			bed_pkg::MODE_ESC: begin
				escape_step(c, last);
			end
			default: begin
				if (!half) begin
					hi_nib = nibble_of(c);
					half   = 1'b1;
				end else begin
					put({hi_nib, nibble_of(c)});
					half = 1'b0;
				end
			end
		endcase
		n = run_out.size();
		for (int k = 0; k < n; k++)
			decoded_due.push_back('{run_out[k], 1'b1, k == n - 1, last && k == n - 1});
		// a final char that yields nothing still closes the string with an empty beat
		if (last && n == 0)
			decoded_due.push_back('{8'd0, 1'b0, 1'b1, 1'b1});
		if (last)
			clear();
	endfunction

	task report(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	task check_beat(logic [7:0] data, logic valid, logic run_end, logic str_end);
		beat_t want;
		if (decoded_due.size() == 0) begin
			report($sformatf("beat %h/%b/%b/%b with nothing expected",
				data, valid, run_end, str_end));
		end else begin
			want = decoded_due.pop_front();
			if (data !== want.data)
				report($sformatf("out_byte %h, want %h", data, want.data));
			if (valid !== want.valid)
				report($sformatf("byte_valid %b, want %b", valid, want.valid));
			if (run_end !== want.run_end)
				report($sformatf("run_last %b, want %b", run_end, want.run_end));
			if (str_end !== want.str_end)
				report($sformatf("string_end %b, want %b", str_end, want.str_end));
		end
	endtask
endclass

module bytea_escape_decoder_test;
	import bed_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int ItemTarget = 230;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'd0;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_end;

	// values seen mid-cycle, used at the following rising edge
	logic       rst_smp = 1'b0;
	logic       is_smp = 1'b1;
	logic       ov_smp = 1'b0;
	logic       os_smp = 1'b0;
	logic [7:0] ob_smp;
	logic       bv_smp, rl_smp, se_smp;

	bytea_scoreboard sb;
	logic [7:0]      msg[$];
	logic            quiet = 1'b0;
	int              cycles = 0;
	int              sent = 0;
	string           hex_digits = "0123456789abcdefABCDEF";

	bytea_escape_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.run_last(run_last),
		.string_end(string_end)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		rst_smp = arst_n;
		is_smp  = in_stall;
		ov_smp  = out_valid;
		os_smp  = out_stall;
		ob_smp  = out_byte;
		bv_smp  = byte_valid;
		rl_smp  = run_last;
		se_smp  = string_end;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (rst_smp && ov_smp && !os_smp)
			sb.check_beat(ob_smp, bv_smp, rl_smp, se_smp);

	function automatic int pick_wait();
		if (quiet || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= c;
		in_last  <= last;
		do @(posedge clk); while (is_smp);
		sb.unescape_char(c, last);
	endtask

	task automatic play_msg();
		for (int i = 0; i < msg.size(); i++)
			send_char(msg[i], i == msg.size() - 1);
		sent += msg.size();
	endtask

	task automatic load_text(input string s);
		msg.delete();
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endtask

	task automatic add_escape_text(input int n);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: msg.push_back(8'($urandom_range(0, 255)));
				4: begin
					msg.push_back(BSLASH);
					msg.push_back(BSLASH);
				end
				5, 6: begin
					msg.push_back(BSLASH);
					repeat (3) msg.push_back(CH_0 + 8'($urandom_range(0, 7)));
				end
				7: begin
					// escape followed by zero to two digits and a random byte, which breaks it unless octal
					msg.push_back(BSLASH);
					repeat ($urandom_range(0, 2))
						msg.push_back(CH_0 + 8'($urandom_range(0, 7)));
					msg.push_back(8'($urandom_range(0, 255)));
				end
				8: msg.push_back(CH_0 + 8'($urandom_range(0, 9)));
				default: msg.push_back(BSLASH);
			endcase
		end
	endtask

	// receive side: raise out_stall for a random spell ahead of each beat, or not at all
	initial begin
		int n;
		forever begin
			n = pick_wait();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(rst_smp && ov_smp));
		end
	end

	initial begin
		int n;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// hex form: both letter cases, an invalid digit, odd trailing digit dropped
		load_text("\\xFf09aGA7z");
		play_msg();
		// doubled backslash, wrapping octal, escapes broken after two digits and after none, final backslash
		load_text("\\\\\\401\\12q\\q\\");
		play_msg();
		msg.delete();
		msg.push_back(8'hFF);
		msg.push_back(8'h00);
		play_msg();

		while (sent < ItemTarget) begin
			msg.delete();
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: add_escape_text($urandom_range(1, 8));
				5, 6, 7: begin
					msg.push_back(BSLASH);
					msg.push_back(CH_X);
					n = $urandom_range(0, 12);
					repeat (n) begin
						if ($urandom_range(0, 7) == 0)
							msg.push_back(8'($urandom_range(0, 255)));
						else
							msg.push_back(hex_digits[$urandom_range(0, 21)]);
					end
				end
				default: begin
					n = $urandom_range(1, 10);
					repeat (n)
						msg.push_back(($urandom_range(0, 3) == 0) ? BSLASH
							: 8'($urandom_range(0, 255)));
				end
			endcase
			play_msg();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/bed_pkg.sv
rtl/core/bed_front.sv
rtl/core/bed_queue.sv
rtl/core/bed_back.sv
rtl/core/bytea_escape_decoder.sv
sim/bytea_escape_decoder_test.sv
